@@ rtl/int_to_decimal_with_commas_core_macros.svh @@
// Assertion helpers for the file that asserts, the top-level core.
`ifndef INT_TO_DECIMAL_WITH_COMMAS_CORE_MACROS_SVH
`define INT_TO_DECIMAL_WITH_COMMAS_CORE_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define I2D_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("i2d check failed");

// Check that a trigger is followed in the next cycle by a condition.
`define I2D_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("i2d sequence check failed");

`endif

@@ rtl/i2d_pkg.sv @@
package i2d_pkg;

    localparam int BIN_W      = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(BIN_W + 1);
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int GROUP      = 3;

    localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_DIGITS - 1);
    localparam logic [1:0]       MOD_TOP = 2'((NUM_DIGITS - 1) % GROUP);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic done;
        logic negative;
    } conv_res_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } emit_stat_t;

endpackage

@@ rtl/i2d_dabble.sv @@
module i2d_dabble
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              value,
    output i2d_pkg::conv_res_t       res,
    output i2d_pkg::bcd_t            bcd
);

    logic [i2d_pkg::BIN_W-1:0] bin_reg, bin_next;
    i2d_pkg::bcd_t             bcd_reg, bcd_next;
    logic [i2d_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      neg_reg, neg_next;
    logic                      done_reg, done_next;
    i2d_pkg::bcd_t             adj;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next = value[63];
            bin_next = value[63] ? (~value + 64'd1) : value;
            bcd_next = '0;
            cnt_next = i2d_pkg::CNT_W'(i2d_pkg::BIN_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[i2d_pkg::BCD_W-2:0], bin_reg[i2d_pkg::BIN_W-1]};
            bin_next = {bin_reg[i2d_pkg::BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == i2d_pkg::CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign res.done     = done_reg;
    assign res.negative = neg_reg;
    assign bcd          = bcd_reg;

endmodule

@@ rtl/i2d_emit.sv @@
module i2d_emit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  i2d_pkg::conv_res_t       res,
    input  i2d_pkg::bcd_t            bcd,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [7:0]               character,
    output logic                     last,
    output i2d_pkg::emit_stat_t      stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SKIP  = 3'd1;
    localparam logic [2:0] ST_SIGN  = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_COMMA = 3'd4;

    logic [2:0]                state_reg, state_next;
    i2d_pkg::bcd_t             sh_reg, sh_next;
    logic [i2d_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [1:0]                mod_reg, mod_next;
    logic                      neg_reg, neg_next;
    logic                      vld_reg, vld_next;
    logic [7:0]                char_reg, char_next;
    logic                      last_reg, last_next;
    logic                      fin;
    logic                      slot;
    logic [3:0]                top;

    assign slot = !vld_reg || !out_stall;
    assign top  = sh_reg[i2d_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        pos_next   = pos_reg;
        mod_next   = mod_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        vld_next   = vld_reg && out_stall;
        fin        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (res.done)
                begin
                    sh_next    = bcd;
                    neg_next   = res.negative;
                    pos_next   = i2d_pkg::POS_TOP;
                    mod_next   = i2d_pkg::MOD_TOP;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (top == 4'd0 && pos_reg != '0)
                begin
                    sh_next  = {sh_reg[i2d_pkg::BCD_W-5:0], 4'd0};
                    pos_next = pos_reg - 1'b1;
                    mod_next = (mod_reg == 2'd0) ? 2'(i2d_pkg::GROUP - 1) : mod_reg - 2'd1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot)
                begin
                    vld_next   = 1'b1;
                    char_next  = i2d_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot)
                begin
                    vld_next  = 1'b1;
                    char_next = i2d_pkg::CHAR_ZERO + {4'd0, top};
                    last_next = (pos_reg == '0);
                    sh_next   = {sh_reg[i2d_pkg::BCD_W-5:0], 4'd0};
                    pos_next  = pos_reg - 1'b1;
                    mod_next  = (mod_reg == 2'd0) ? 2'(i2d_pkg::GROUP - 1) : mod_reg - 2'd1;
                    if (pos_reg == '0)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (mod_reg == 2'd0)
                    begin
                        state_next = ST_COMMA;
                    end
                end
            end
            ST_COMMA:
            begin
                if (slot)
                begin
                    vld_next   = 1'b1;
                    char_next  = i2d_pkg::CHAR_COMMA;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        pos_reg  <= pos_next;
        mod_reg  <= mod_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid   = vld_reg;
    assign character   = char_reg;
    assign last        = last_reg;
    assign stat.busy   = (state_reg != ST_IDLE);
    assign stat.finish = fin;

endmodule

@@ rtl/int_to_decimal_with_commas_core.sv @@
// From the accepting edge, a request runs the 64-step binary-to-BCD shift loop, is handed to the
// emitter, skips its leading zero digits (0 to 19 of them) and loads its first character to the output.
// A new request is taken only once the last character of the text has been loaded into the output
// register; an output stall holds the emitter while a character waits. The 64-step binary-to-BCD
// shift loop and the one-character output register set the request rate.
// Reset (rst_n, async, active low) clears all control state; no result is pending.
`include "int_to_decimal_with_commas_core_macros.svh"

module int_to_decimal_with_commas_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last
);

    // One request in flight at a time: hold the input from accept until
    // the last character of its text has been loaded into the output register.
    logic                busy_reg, busy_next;
    logic                accept;
    i2d_pkg::conv_res_t  conv_res;
    i2d_pkg::bcd_t       conv_bcd;
    i2d_pkg::emit_stat_t emit_stat;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (emit_stat.finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Form the magnitude and shift it, one bit per cycle, into 20 BCD digits.
    i2d_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (value),
        .res   (conv_res),
        .bcd   (conv_bcd)
    );

    // Skip leading zeros, then emit sign, digits and commas most significant first.
    i2d_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (conv_res),
        .bcd       (conv_bcd),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .character (character),
        .last      (last),
        .stat      (emit_stat)
    );

    `I2D_ASSERT(a_done_when_emit_idle, !(conv_res.done && emit_stat.busy))
    `I2D_ASSERT(a_emit_only_when_busy, !(emit_stat.busy && !busy_reg))
    `I2D_ASSERT_NEXT(a_finish_shows_last, emit_stat.finish, out_valid && last)
    `I2D_ASSERT_NEXT(a_accept_sets_busy, accept, busy_reg)

endmodule
